### sv/mie_pkg.sv
// Shared types and constants of the MIPS-subset execution core.
package mie_pkg;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] load_address;
        logic [31:0] load_data;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] next_pc;
        logic        reg_written;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic [15:0] trap_code;
        logic [31:0] arg_value;
        logic        core_running;
    } t_out_item;

    // item kinds
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;

    // status codes
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_HALTED    = 4'd1;
    localparam logic [3:0] ST_BAD_PC    = 4'd2;
    localparam logic [3:0] ST_BAD_JUMP  = 4'd3;
    localparam logic [3:0] ST_UNALIGNED = 4'd4;
    localparam logic [3:0] ST_DIV_ZERO  = 4'd5;
    localparam logic [3:0] ST_DATA_OOR  = 4'd6;
    localparam logic [3:0] ST_UNIMPL    = 4'd7;
    localparam logic [3:0] ST_SYS_OUT   = 4'd8;
    localparam logic [3:0] ST_SYS_IN    = 4'd9;
    localparam logic [3:0] ST_EXIT      = 4'd10;
    localparam logic [3:0] ST_SYS_BAD   = 4'd11;

    // multiply/divide unit operations
    localparam logic [1:0] MD_MULT  = 2'd0;
    localparam logic [1:0] MD_MULTU = 2'd1;
    localparam logic [1:0] MD_DIV   = 2'd2;
    localparam logic [1:0] MD_DIVU  = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] a;
        logic [31:0] b;
    } t_md_req;

    // primary opcodes
    localparam logic [5:0] OPC_RTYPE = 6'h00;
    localparam logic [5:0] OPC_J     = 6'h02;
    localparam logic [5:0] OPC_JAL   = 6'h03;
    localparam logic [5:0] OPC_BEQ   = 6'h04;
    localparam logic [5:0] OPC_BNE   = 6'h05;
    localparam logic [5:0] OPC_BLEZ  = 6'h06;
    localparam logic [5:0] OPC_BGTZ  = 6'h07;
    localparam logic [5:0] OPC_ADDI  = 6'h08;
    localparam logic [5:0] OPC_ADDIU = 6'h09;
    localparam logic [5:0] OPC_SLTI  = 6'h0A;
    localparam logic [5:0] OPC_SLTIU = 6'h0B;
    localparam logic [5:0] OPC_ANDI  = 6'h0C;
    localparam logic [5:0] OPC_ORI   = 6'h0D;
    localparam logic [5:0] OPC_XORI  = 6'h0E;
    localparam logic [5:0] OPC_LUI   = 6'h0F;
    localparam logic [5:0] OPC_LLO   = 6'h18;
    localparam logic [5:0] OPC_LHI   = 6'h19;
    localparam logic [5:0] OPC_TRAP  = 6'h1A;
    localparam logic [5:0] OPC_LB    = 6'h20;
    localparam logic [5:0] OPC_LH    = 6'h21;
    localparam logic [5:0] OPC_LW    = 6'h23;
    localparam logic [5:0] OPC_LBU   = 6'h24;
    localparam logic [5:0] OPC_LHU   = 6'h25;
    localparam logic [5:0] OPC_SB    = 6'h28;
    localparam logic [5:0] OPC_SH    = 6'h29;
    localparam logic [5:0] OPC_SW    = 6'h2B;

    // function codes
    localparam logic [5:0] FN_SLL   = 6'h00;
    localparam logic [5:0] FN_SRL   = 6'h02;
    localparam logic [5:0] FN_SRA   = 6'h03;
    localparam logic [5:0] FN_SLLV  = 6'h04;
    localparam logic [5:0] FN_SRLV  = 6'h06;
    localparam logic [5:0] FN_SRAV  = 6'h07;
    localparam logic [5:0] FN_JR    = 6'h08;
    localparam logic [5:0] FN_JALR  = 6'h09;
    localparam logic [5:0] FN_MFHI  = 6'h10;
    localparam logic [5:0] FN_MTHI  = 6'h11;
    localparam logic [5:0] FN_MFLO  = 6'h12;
    localparam logic [5:0] FN_MTLO  = 6'h13;
    localparam logic [5:0] FN_MULT  = 6'h18;
    localparam logic [5:0] FN_MULTU = 6'h19;
    localparam logic [5:0] FN_DIV   = 6'h1A;
    localparam logic [5:0] FN_DIVU  = 6'h1B;
    localparam logic [5:0] FN_ADD   = 6'h20;
    localparam logic [5:0] FN_ADDU  = 6'h21;
    localparam logic [5:0] FN_SUB   = 6'h22;
    localparam logic [5:0] FN_SUBU  = 6'h23;
    localparam logic [5:0] FN_AND   = 6'h24;
    localparam logic [5:0] FN_OR    = 6'h25;
    localparam logic [5:0] FN_XOR   = 6'h26;
    localparam logic [5:0] FN_NOR   = 6'h27;
    localparam logic [5:0] FN_SLT   = 6'h2A;
    localparam logic [5:0] FN_SLTU  = 6'h2B;

    localparam logic [4:0] REG_LINK = 5'd31;
    localparam logic [4:0] REG_ARG  = 5'd4;

endpackage

### sv/mips_instruction_execute_top.sv
// MIPS-subset core: sequencer, register file, word memory and multiply/divide unit.
// Load, start, halted and bad-PC steps go from dispatch to done; other steps pass decode,
// two register reads and execute; loads and sub-word stores add a memory read; mult/div
// wait on the 32-step unit. One item at a time: busy drops at the edge that takes the result.
// Reset (synchronous, active low) runs a clearing pass over the MEM_WORDS memory words
// and the registers with busy high; the result shows for one cycle and cannot be stalled.
module mips_instruction_execute_top import mie_pkg::*; #(
    parameter int MEM_WORDS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_item    i_item,
    output logic        o_strobe,
    output t_out_item   o_result,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data
);
    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [33:0] MemBytes = 34'(MEM_WORDS) << 2;
    localparam logic [AW-1:0] ClrLast = AW'(MEM_WORDS - 1);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DISP = 4'd2;
    localparam logic [3:0] S_DEC  = 4'd3;
    localparam logic [3:0] S_RDA  = 4'd4;
    localparam logic [3:0] S_RDB  = 4'd5;
    localparam logic [3:0] S_EXE  = 4'd6;
    localparam logic [3:0] S_MD   = 4'd7;
    localparam logic [3:0] S_LD   = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0]    r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    t_in_item      r_item, n_item;
    logic [31:0]   r_instr, n_instr;
    logic [31:0]   r_a, n_a;
    logic [31:0]   r_b, n_b;
    logic [31:0]   r_pc, n_pc;
    logic          r_run, n_run;
    logic [31:0]   r_hi, n_hi;
    logic [31:0]   r_lo, n_lo;
    logic [31:0]   r_ea, n_ea;
    logic [31:0]   r_start_addr;
    t_out_item     r_res, n_res;

    logic          rf_we;
    logic [4:0]    rf_waddr, rf_raddr;
    logic [31:0]   rf_wdata, rf_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [31:0]   mem_wdata, mem_rdata;
    logic          md_start, md_done;
    t_md_req       md_req;
    logic [31:0]   md_hi, md_lo;

    mie_ram #(.WIDTH(32), .DEPTH(32)) u_rf (
        .i_clk  (i_clk),
        .i_we   (rf_we),
        .i_waddr(rf_waddr),
        .i_wdata(rf_wdata),
        .i_raddr(rf_raddr),
        .o_rdata(rf_rdata)
    );

    mie_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    mie_muldiv u_md (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(md_start),
        .i_req  (md_req),
        .o_done (md_done),
        .o_hi   (md_hi),
        .o_lo   (md_lo)
    );

    // instruction fields
    logic [5:0]  opc, funct;
    logic [4:0]  f_rt, f_rd, f_sa;
    logic [15:0] imm;
    logic [31:0] simm, zimm, tgt, boff;
    logic [31:0] ea;
    logic [1:0]  bsel;
    logic [4:0]  bsh;
    logic [7:0]  lbyte;
    logic [15:0] lhalf;
    logic        wen;
    logic [4:0]  widx;
    logic [31:0] wval;
    logic [3:0]  st;

    always_comb begin
        opc   = r_instr[31:26];
        f_rt  = r_instr[20:16];
        f_rd  = r_instr[15:11];
        f_sa  = r_instr[10:6];
        funct = r_instr[5:0];
        imm   = r_instr[15:0];
        simm  = {{16{imm[15]}}, imm};
        zimm  = {16'd0, imm};
        tgt   = {6'd0, r_instr[25:0]};
        boff  = {simm[29:0], 2'b00};
        ea    = r_a + simm;
        bsel  = r_ea[1:0];
        bsh   = {~bsel, 3'b000};
        lbyte = 8'(mem_rdata >> bsh);
        lhalf = bsel[1] ? mem_rdata[15:0] : mem_rdata[31:16];
    end

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_item   = r_item;
        n_instr  = r_instr;
        n_a      = r_a;
        n_b      = r_b;
        n_pc     = r_pc;
        n_run    = r_run;
        n_hi     = r_hi;
        n_lo     = r_lo;
        n_ea     = r_ea;
        n_res    = r_res;
        rf_we    = 1'b0;
        rf_waddr = 5'd0;
        rf_wdata = 32'd0;
        rf_raddr = 5'd0;
        mem_we   = 1'b0;
        mem_waddr = r_item.load_address[AW+1:2];
        mem_wdata = r_item.load_data;
        mem_raddr = r_pc[AW+1:2];
        md_start = 1'b0;
        md_req   = '{kind: MD_MULT, a: r_a, b: r_b};
        wen      = 1'b0;
        widx     = 5'd0;
        wval     = 32'd0;
        st       = ST_OK;

        unique case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = 32'd0;
                rf_we     = (r_clr < AW'(32));
                rf_waddr  = r_clr[4:0];
                n_clr     = r_clr + AW'(1);
                if (r_clr == ClrLast) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_item  = i_item;
                    n_res   = '0;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_DONE;
                unique case (r_item.op)
                    OP_LOAD: begin
                        if ({2'b00, r_item.load_address} < MemBytes) begin
                            mem_we = 1'b1;
                        end else begin
                            n_res.status = ST_DATA_OOR;
                        end
                    end
                    OP_START: begin
                        n_pc  = r_start_addr;
                        n_run = 1'b1;
                    end
                    OP_STEP: begin
                        if (!r_run) begin
                            n_res.status = ST_HALTED;
                        end else if (r_pc[1:0] != 2'b00 || {2'b00, r_pc} >= MemBytes) begin
                            n_res.status = ST_BAD_PC;
                            n_run = 1'b0;
                        end else begin
                            n_state = S_DEC;
                        end
                    end
                    default: n_res.status = ST_UNIMPL;
                endcase
            end
            S_DEC: begin
                n_instr  = mem_rdata;
                n_pc     = r_pc + 32'd4;
                rf_raddr = mem_rdata[25:21];
                n_state  = S_RDA;
            end
            S_RDA: begin
                n_a      = rf_rdata;
                // a syscall reads the argument register in place of rt
                rf_raddr = (opc == OPC_TRAP) ? REG_ARG : f_rt;
                n_state  = S_RDB;
            end
            S_RDB: begin
                n_b     = rf_rdata;
                n_state = S_EXE;
            end
            S_EXE: begin
                n_state = S_DONE;
                unique case (opc)
                    OPC_RTYPE: begin
                        unique case (funct)
                            FN_SLL:  begin wen = 1'b1; widx = f_rd; wval = r_b << f_sa; end
                            FN_SRL:  begin wen = 1'b1; widx = f_rd; wval = r_b >> f_sa; end
                            FN_SRA:  begin
                                wen = 1'b1; widx = f_rd; wval = 32'($signed(r_b) >>> f_sa);
                            end
                            FN_SLLV: begin wen = 1'b1; widx = f_rd; wval = r_b << r_a[4:0]; end
                            FN_SRLV: begin wen = 1'b1; widx = f_rd; wval = r_b >> r_a[4:0]; end
                            FN_SRAV: begin
                                wen = 1'b1; widx = f_rd;
                                wval = 32'($signed(r_b) >>> r_a[4:0]);
                            end
                            FN_JR: begin
                                if (r_a[1:0] != 2'b00) st = ST_BAD_JUMP;
                                else n_pc = r_a;
                            end
                            FN_JALR: begin
                                if (r_a[1:0] != 2'b00) begin
                                    st = ST_BAD_JUMP;
                                end else begin
                                    wen = 1'b1; widx = REG_LINK; wval = r_pc; n_pc = r_a;
                                end
                            end
                            FN_MFHI: begin wen = 1'b1; widx = f_rd; wval = r_hi; end
                            FN_MTHI: n_hi = r_a;
                            FN_MFLO: begin wen = 1'b1; widx = f_rd; wval = r_lo; end
                            FN_MTLO: n_lo = r_a;
                            FN_MULT, FN_MULTU, FN_DIV, FN_DIVU: begin
                                if ((funct == FN_DIV || funct == FN_DIVU) && r_b == 32'd0) begin
                                    st = ST_DIV_ZERO;
                                end else begin
                                    md_start = 1'b1;
                                    md_req.kind = funct[1:0];
                                    n_state = S_MD;
                                end
                            end
                            FN_ADD, FN_ADDU: begin wen = 1'b1; widx = f_rd; wval = r_a + r_b; end
                            FN_SUB, FN_SUBU: begin wen = 1'b1; widx = f_rd; wval = r_a - r_b; end
                            FN_AND:  begin wen = 1'b1; widx = f_rd; wval = r_a & r_b; end
                            FN_OR:   begin wen = 1'b1; widx = f_rd; wval = r_a | r_b; end
                            FN_XOR:  begin wen = 1'b1; widx = f_rd; wval = r_a ^ r_b; end
                            FN_NOR:  begin wen = 1'b1; widx = f_rd; wval = ~(r_a | r_b); end
                            FN_SLT:  begin
                                wen = 1'b1; widx = f_rd;
                                wval = {31'd0, $signed(r_a) < $signed(r_b)};
                            end
                            FN_SLTU: begin wen = 1'b1; widx = f_rd; wval = {31'd0, r_a < r_b}; end
                            default: st = ST_UNIMPL;
                        endcase
                    end
                    OPC_J: begin
                        if (tgt[1:0] != 2'b00) st = ST_BAD_JUMP;
                        else n_pc = tgt;
                    end
                    OPC_JAL: begin
                        if (tgt[1:0] != 2'b00) begin
                            st = ST_BAD_JUMP;
                        end else begin
                            wen = 1'b1; widx = REG_LINK; wval = r_pc; n_pc = tgt;
                        end
                    end
                    OPC_BEQ:  if (r_a == r_b) n_pc = r_pc + boff;
                    OPC_BNE:  if (r_a != r_b) n_pc = r_pc + boff;
                    OPC_BLEZ: if (r_a == 32'd0 || r_a[31]) n_pc = r_pc + boff;
                    OPC_BGTZ: if (r_a != 32'd0 && !r_a[31]) n_pc = r_pc + boff;
                    OPC_ADDI, OPC_ADDIU: begin wen = 1'b1; widx = f_rt; wval = r_a + simm; end
                    OPC_SLTI: begin
                        wen = 1'b1; widx = f_rt; wval = {31'd0, $signed(r_a) < $signed(simm)};
                    end
                    OPC_SLTIU: begin wen = 1'b1; widx = f_rt; wval = {31'd0, r_a < simm}; end
                    OPC_ANDI: begin wen = 1'b1; widx = f_rt; wval = r_a & zimm; end
                    OPC_ORI:  begin wen = 1'b1; widx = f_rt; wval = r_a | zimm; end
                    OPC_XORI: begin wen = 1'b1; widx = f_rt; wval = r_a ^ zimm; end
                    OPC_LUI:  begin wen = 1'b1; widx = f_rt; wval = zimm; end
                    OPC_LLO:  begin wen = 1'b1; widx = f_rt; wval = {r_b[31:16], imm}; end
                    OPC_LHI:  begin wen = 1'b1; widx = f_rt; wval = {imm, r_b[15:0]}; end
                    OPC_TRAP: begin
                        n_res.trap_code = imm;
                        n_res.arg_value = r_b;
                        if (imm <= 16'd2)      st = ST_SYS_OUT;
                        else if (imm <= 16'd4) st = ST_SYS_IN;
                        else if (imm == 16'd5) st = ST_EXIT;
                        else                   st = ST_SYS_BAD;
                    end
                    OPC_LB, OPC_LBU, OPC_LH, OPC_LHU, OPC_LW,
                    OPC_SB, OPC_SH, OPC_SW: begin
                        if (((opc == OPC_LH || opc == OPC_LHU || opc == OPC_SH) && ea[0])
                            || ((opc == OPC_LW || opc == OPC_SW) && ea[1:0] != 2'b00)) begin
                            st = ST_UNALIGNED;
                        end else if ({2'b00, ea} >= MemBytes) begin
                            st = ST_DATA_OOR;
                        end else if (opc == OPC_SW) begin
                            mem_we    = 1'b1;
                            mem_waddr = ea[AW+1:2];
                            mem_wdata = r_b;
                        end else begin
                            // read the word, finish the load or the partial store next
                            mem_raddr = ea[AW+1:2];
                            n_ea      = ea;
                            n_state   = S_LD;
                        end
                    end
                    default: st = ST_UNIMPL;
                endcase
                n_res.status = st;
                if (st != ST_OK && st != ST_SYS_OUT) begin
                    n_run = 1'b0;
                end
            end
            S_MD: begin
                if (md_done) begin
                    n_hi    = md_hi;
                    n_lo    = md_lo;
                    n_state = S_DONE;
                end
            end
            S_LD: begin
                mem_waddr = r_ea[AW+1:2];
                mem_wdata = mem_rdata;
                unique case (opc)
                    OPC_LB:  begin wen = 1'b1; widx = f_rt; wval = {{24{lbyte[7]}}, lbyte}; end
                    OPC_LBU: begin wen = 1'b1; widx = f_rt; wval = {24'd0, lbyte}; end
                    OPC_LH:  begin wen = 1'b1; widx = f_rt; wval = {{16{lhalf[15]}}, lhalf}; end
                    OPC_LHU: begin wen = 1'b1; widx = f_rt; wval = {16'd0, lhalf}; end
                    OPC_LW:  begin wen = 1'b1; widx = f_rt; wval = mem_rdata; end
                    OPC_SB: begin
                        mem_we    = 1'b1;
                        mem_wdata = (mem_rdata & ~(32'hFF << bsh)) | ({24'd0, r_b[7:0]} << bsh);
                    end
                    OPC_SH: begin
                        mem_we = 1'b1;
                        if (bsel[1]) mem_wdata = {mem_rdata[31:16], r_b[15:0]};
                        else         mem_wdata = {r_b[15:0], mem_rdata[15:0]};
                    end
                    default: ;
                endcase
                n_state = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase

        // register zero is hard-wired: drop and do not report
        if (wen && widx != 5'd0) begin
            rf_we    = 1'b1;
            rf_waddr = widx;
            rf_wdata = wval;
            n_res.reg_written = 1'b1;
            n_res.reg_index   = widx;
            n_res.reg_value   = wval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_clr        <= '0;
            r_pc         <= 32'd0;
            r_run        <= 1'b0;
            r_hi         <= 32'd0;
            r_lo         <= 32'd0;
            r_start_addr <= 32'd0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_pc    <= n_pc;
            r_run   <= n_run;
            r_hi    <= n_hi;
            r_lo    <= n_lo;
            if (i_cfg_we) begin
                r_start_addr <= i_cfg_data;
            end
        end
        r_item  <= n_item;
        r_instr <= n_instr;
        r_a     <= n_a;
        r_b     <= n_b;
        r_ea    <= n_ea;
        r_res   <= n_res;
    end

    always_comb begin
        busy     = (r_state != S_IDLE);
        o_strobe = (r_state == S_DONE);
        o_result = r_res;
        o_result.next_pc      = r_pc;
        o_result.core_running = r_run;
    end
endmodule

### sv/mie_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### sv/mie_muldiv.sv
// Iterative multiply/divide unit: one shift-add or shift-subtract step per cycle.
module mie_muldiv import mie_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_md_req     i_req,
    output logic        o_done,
    output logic [31:0] o_hi,
    output logic [31:0] o_lo
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIX  = 2'd2;

    logic [1:0]  r_state, n_state;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_is_div, n_is_div;
    logic        r_neg_q, n_neg_q;
    logic        r_neg_r, n_neg_r;
    logic [31:0] r_hi, n_hi;
    logic [31:0] r_lo, n_lo;
    logic [31:0] r_d, n_d;

    logic        sgn;
    logic [32:0] sum;
    logic [32:0] rem_sh;
    logic [32:0] diff;
    logic [63:0] prod_neg;

    always_comb begin
        sgn      = (i_req.kind == MD_MULT) || (i_req.kind == MD_DIV);
        sum      = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_d} : 33'd0);
        rem_sh   = {r_hi, r_lo[31]};
        diff     = rem_sh - {1'b0, r_d};
        prod_neg = 64'd0 - {r_hi, r_lo};

        n_state  = r_state;
        n_cnt    = r_cnt;
        n_is_div = r_is_div;
        n_neg_q  = r_neg_q;
        n_neg_r  = r_neg_r;
        n_hi     = r_hi;
        n_lo     = r_lo;
        n_d      = r_d;
        o_done   = 1'b0;
        o_hi     = r_hi;
        o_lo     = r_lo;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_is_div = (i_req.kind == MD_DIV) || (i_req.kind == MD_DIVU);
                    n_neg_q  = sgn && (i_req.a[31] ^ i_req.b[31]);
                    n_neg_r  = sgn && i_req.a[31];
                    n_hi     = 32'd0;
                    n_lo     = (sgn && i_req.a[31]) ? 32'd0 - i_req.a : i_req.a;
                    n_d      = (sgn && i_req.b[31]) ? 32'd0 - i_req.b : i_req.b;
                    n_cnt    = 5'd0;
                    n_state  = S_RUN;
                end
            end
            S_RUN: begin
                if (r_is_div) begin
                    if (!diff[32]) begin
                        n_hi = diff[31:0];
                        n_lo = {r_lo[30:0], 1'b1};
                    end else begin
                        n_hi = rem_sh[31:0];
                        n_lo = {r_lo[30:0], 1'b0};
                    end
                end else begin
                    n_hi = sum[32:1];
                    n_lo = {sum[0], r_lo[31:1]};
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                // apply signs of the magnitudes
                o_done = 1'b1;
                if (r_is_div) begin
                    o_lo = r_neg_q ? 32'd0 - r_lo : r_lo;
                    o_hi = r_neg_r ? 32'd0 - r_hi : r_hi;
                end else if (r_neg_q) begin
                    o_hi = prod_neg[63:32];
                    o_lo = prod_neg[31:0];
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 5'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_is_div <= n_is_div;
        r_neg_q  <= n_neg_q;
        r_neg_r  <= n_neg_r;
        r_hi     <= n_hi;
        r_lo     <= n_lo;
        r_d      <= n_d;
    end
endmodule

### sv/mie_checker.sv
// Port-level checker for the execution core, bound to the top level.
module mie_checker import mie_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input logic      o_strobe,
    input t_out_item o_result
);
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe while idle");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result repeated");

    a_halted_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_result.status == ST_HALTED || o_result.status == ST_BAD_PC)
        |-> !o_result.core_running)
        else $error("halt status with run flag set");

    a_reg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.reg_written |-> o_result.reg_index != 5'd0)
        else $error("write to register zero reported");
endmodule

bind mips_instruction_execute_top mie_checker u_mie_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_strobe(o_strobe),
    .o_result(o_result)
);
